// ===== sv/grid_path_move_engine_defines.svh =====
// Assertion macros shared by the grid path move engine modules.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef GRID_PATH_MOVE_ENGINE_DEFINES_SVH
`define GRID_PATH_MOVE_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define GPME_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GPME_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define GPME_ASSERT(lbl, prop, msg)
`define GPME_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/gpme_pkg.sv =====
// Shared codes and types for the grid path move engine.
// No dependencies; imported by gpme_search and the top level.
package gpme_pkg;

  localparam int CFG_W = 5;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_MOVE  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] STS_DONE         = 2'd0;
  localparam logic [1:0] STS_OCCUPIED     = 2'd1;
  localparam logic [1:0] STS_NO_PATH      = 2'd2;
  localparam logic [1:0] STS_OUT_OF_RANGE = 2'd3;

  localparam logic CFG_ROW_COUNT = 1'b0;
  localparam logic CFG_COL_COUNT = 1'b1;

  localparam logic [CFG_W-1:0] COUNT_RESET = 5'd9;

  typedef struct packed {
    logic done;
    logic found;
  } srch_stat_t;

endpackage

// ===== sv/grid_path_move_engine.sv =====
// Top level of the grid path move engine: command sequencer, size registers, grid memory.
// Depends on gpme_pkg, gpme_search and grid_path_move_engine_defines.svh.
`include "grid_path_move_engine_defines.svh"
// Requests are taken when start is high and busy is low, one at a time. A write request
// completes in the accepting cycle and busy stays low; its result strobes in the next cycle.
// A read answers from the grid memory's registered read port. A move that fails on range
// answers like a write; one that meets an occupied target, or whose source equals its
// target, answers once the target colour is read. Otherwise it runs a breadth-first
// search held in the search unit's own memories: a clear of the mark memory
// (MAX_ROWS*MAX_COLS rounded up to powers of two), then a pop of each queued cell and a
// look at each in-area neighbour; a successful move then copies the colour and empties
// the source. After reset the grid memory is cleared one cell a cycle with busy high;
// size register writes are taken throughout.
// Each result is shown for exactly one cycle on out_valid: take it then, there is no stall.
module grid_path_move_engine
  import gpme_pkg::*;
#(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16,
  parameter int COLOR_BITS = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_cmd,
  input  logic [3:0]       in_from_row,
  input  logic [3:0]       in_from_col,
  input  logic [3:0]       in_to_row,
  input  logic [3:0]       in_to_col,
  input  logic [3:0]       in_color,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [3:0]       out_cell_color
);

  localparam int RB = $clog2(MAX_ROWS);
  localparam int CB = $clog2(MAX_COLS);
  localparam int AW = RB + CB;
  localparam int DEPTH = 1 << AW;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_TGT  = 3'd3;
  localparam logic [2:0] ST_SRCH = 3'd4;
  localparam logic [2:0] ST_SRC  = 3'd5;
  localparam logic [2:0] ST_MOVE = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [AW-1:0]    clr_addr_r, clr_addr_nxt;
  logic [CFG_W-1:0] row_cnt_r, col_cnt_r;
  logic [AW-1:0]    src_r, src_nxt, tgt_r, tgt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic [3:0]       out_color_r, out_color_nxt;

  logic [COLOR_BITS-1:0] grid_mem [DEPTH];
  logic [COLOR_BITS-1:0] grid_rdata;
  logic                  grid_we;
  logic [AW-1:0]         grid_waddr, grid_raddr;
  logic [COLOR_BITS-1:0] grid_wdata;

  logic [7:0]    used_rows, used_cols;
  logic [7:0]    fr8, fc8, tr8, tc8, color8, rd8;
  logic          from_in, to_in;
  logic [AW-1:0] from_addr, to_addr;

  logic          srch_start;
  logic [AW-1:0] srch_raddr;
  srch_stat_t    srch_stat;

  // used sizes saturate at the grid's capacity; zero leaves no cell in use
  assign used_rows = (8'(row_cnt_r) > 8'(MAX_ROWS)) ? 8'(MAX_ROWS) : 8'(row_cnt_r);
  assign used_cols = (8'(col_cnt_r) > 8'(MAX_COLS)) ? 8'(MAX_COLS) : 8'(col_cnt_r);

  assign fr8 = 8'(in_from_row);
  assign fc8 = 8'(in_from_col);
  assign tr8 = 8'(in_to_row);
  assign tc8 = 8'(in_to_col);
  assign color8 = 8'(in_color);
  assign rd8 = 8'(grid_rdata);

  assign from_in = (fr8 < used_rows) && (fc8 < used_cols);
  assign to_in = (tr8 < used_rows) && (tc8 < used_cols);
  // in-area coordinates always fit the address fields
  assign from_addr = {fr8[RB-1:0], fc8[CB-1:0]};
  assign to_addr = {tr8[RB-1:0], tc8[CB-1:0]};

  always_comb begin
    state_nxt = state_r;
    clr_addr_nxt = clr_addr_r;
    src_nxt = src_r;
    tgt_nxt = tgt_r;
    out_valid_nxt = 1'b0;
    out_status_nxt = out_status_r;
    out_color_nxt = out_color_r;
    grid_we = 1'b0;
    grid_waddr = clr_addr_r;
    grid_wdata = '0;
    grid_raddr = from_addr;
    srch_start = 1'b0;
    case (state_r)
      ST_CLR: begin
        // sweep the grid to empty, one cell a cycle
        grid_we = 1'b1;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          out_color_nxt = '0;
          out_status_nxt = STS_DONE;
          src_nxt = from_addr;
          tgt_nxt = to_addr;
          case (in_cmd)
            CMD_WRITE: begin
              out_valid_nxt = 1'b1;
              if (from_in) begin
                grid_we = 1'b1;
                grid_waddr = from_addr;
                grid_wdata = color8[COLOR_BITS-1:0];
              end else begin
                out_status_nxt = STS_OUT_OF_RANGE;
              end
            end
            CMD_READ: begin
              if (from_in) begin
                state_nxt = ST_RD;
              end else begin
                out_valid_nxt = 1'b1;
                out_status_nxt = STS_OUT_OF_RANGE;
              end
            end
            CMD_MOVE: begin
              grid_raddr = to_addr;
              if (from_in && to_in) begin
                state_nxt = ST_TGT;
              end else begin
                out_valid_nxt = 1'b1;
                out_status_nxt = STS_OUT_OF_RANGE;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_RD: begin
        out_valid_nxt = 1'b1;
        out_color_nxt = rd8[3:0];
        state_nxt = ST_IDLE;
      end
      ST_TGT: begin
        // target colour is on the read port now
        if (grid_rdata != '0) begin
          out_valid_nxt = 1'b1;
          out_status_nxt = STS_OCCUPIED;
          state_nxt = ST_IDLE;
        end else if (src_r == tgt_r) begin
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          srch_start = 1'b1;
          state_nxt = ST_SRCH;
        end
      end
      ST_SRCH: begin
        grid_raddr = srch_raddr;
        if (srch_stat.done) begin
          if (srch_stat.found) begin
            grid_raddr = src_r;
            state_nxt = ST_SRC;
          end else begin
            out_valid_nxt = 1'b1;
            out_status_nxt = STS_NO_PATH;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_SRC: begin
        // copy the source colour to the target
        grid_we = 1'b1;
        grid_waddr = tgt_r;
        grid_wdata = grid_rdata;
        state_nxt = ST_MOVE;
      end
      ST_MOVE: begin
        grid_we = 1'b1;
        grid_waddr = src_r;
        out_valid_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (grid_we) begin
      grid_mem[grid_waddr] <= grid_wdata;
    end
    grid_rdata <= grid_mem[grid_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      clr_addr_r <= '0;
      row_cnt_r <= COUNT_RESET;
      col_cnt_r <= COUNT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROW_COUNT: row_cnt_r <= cfg_data;
          CFG_COL_COUNT: col_cnt_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    src_r <= src_nxt;
    tgt_r <= tgt_nxt;
    out_status_r <= out_status_nxt;
    out_color_r <= out_color_nxt;
  end

  gpme_search #(
    .RB(RB),
    .CB(CB),
    .COLOR_BITS(COLOR_BITS)
  ) u_search (
    .clk(clk),
    .rst_n(rst_n),
    .start(srch_start),
    .src(src_r),
    .tgt(tgt_r),
    .used_rows(used_rows),
    .used_cols(used_cols),
    .grid_raddr(srch_raddr),
    .grid_rdata(grid_rdata),
    .stat(srch_stat)
  );

  assign busy = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_cell_color = out_color_r;

  `GPME_ASSERT(a_result_in_idle, out_valid_r |-> state_r == ST_IDLE, "result outside idle")
  `GPME_ASSERT(a_color_only_done, out_valid_r && out_color_r != 4'd0 |-> out_status_r == STS_DONE, "colour with failure status")
  `GPME_ASSERT(a_search_owned, srch_stat.done |-> state_r == ST_SRCH, "search finished unexpectedly")

endmodule

// ===== sv/gpme_search.sv =====
// Breadth-first reachability search over the grid, with its own mark and queue memories.
// Depends on gpme_pkg and grid_path_move_engine_defines.svh; reads the grid through a port.
`include "grid_path_move_engine_defines.svh"
module gpme_search
  import gpme_pkg::*;
#(
  parameter int RB = 4,
  parameter int CB = 4,
  parameter int COLOR_BITS = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [RB+CB-1:0]      src,
  input  logic [RB+CB-1:0]      tgt,
  input  logic [7:0]            used_rows,
  input  logic [7:0]            used_cols,
  output logic [RB+CB-1:0]      grid_raddr,
  input  logic [COLOR_BITS-1:0] grid_rdata,
  output srch_stat_t            stat
);

  localparam int AW = RB + CB;
  localparam int DEPTH = 1 << AW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CLR  = 3'd1;
  localparam logic [2:0] S_SEED = 3'd2;
  localparam logic [2:0] S_POP  = 3'd3;
  localparam logic [2:0] S_CUR  = 3'd4;
  localparam logic [2:0] S_NB   = 3'd5;
  localparam logic [2:0] S_CHK  = 3'd6;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  logic [2:0]    st_r, st_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [AW:0]   head_r, head_nxt, tail_r, tail_nxt;
  logic [AW-1:0] cur_r, cur_nxt, nb_r, nb_nxt;
  logic [1:0]    dir_r, dir_nxt;
  srch_stat_t    stat_r, stat_nxt;

  logic          reached_mem [DEPTH];
  logic [AW-1:0] queue_mem [DEPTH];
  logic          reached_q;
  logic [AW-1:0] queue_q;

  logic          rch_we, rch_wdata;
  logic [AW-1:0] rch_waddr, rch_raddr;
  logic          q_we;
  logic [AW-1:0] q_waddr, q_wdata, q_raddr;

  logic [RB-1:0] cur_row;
  logic [CB-1:0] cur_col;
  logic [7:0]    row8, col8;
  logic          nb_ok;
  logic [AW-1:0] nb_c;
  logic          adv;

  assign cur_row = cur_r[AW-1:CB];
  assign cur_col = cur_r[CB-1:0];
  assign row8 = 8'(cur_row);
  assign col8 = 8'(cur_col);

  // neighbour of the current cell in the current direction, and whether it lies in the area
  always_comb begin
    nb_ok = 1'b0;
    nb_c = cur_r;
    case (dir_r)
      DIR_UP: begin
        nb_ok = (row8 != 8'd0);
        nb_c = {cur_row - RB'(1), cur_col};
      end
      DIR_DOWN: begin
        nb_ok = ((row8 + 8'd1) < used_rows);
        nb_c = {cur_row + RB'(1), cur_col};
      end
      DIR_LEFT: begin
        nb_ok = (col8 != 8'd0);
        nb_c = {cur_row, cur_col - CB'(1)};
      end
      DIR_RIGHT: begin
        nb_ok = ((col8 + 8'd1) < used_cols);
        nb_c = {cur_row, cur_col + CB'(1)};
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
  end

  assign grid_raddr = nb_c;

  always_comb begin
    st_nxt = st_r;
    addr_nxt = addr_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    cur_nxt = cur_r;
    nb_nxt = nb_r;
    dir_nxt = dir_r;
    stat_nxt = stat_r;
    stat_nxt.done = 1'b0;
    rch_we = 1'b0;
    rch_waddr = addr_r;
    rch_wdata = 1'b0;
    rch_raddr = nb_c;
    q_we = 1'b0;
    q_waddr = tail_r[AW-1:0];
    q_wdata = nb_r;
    q_raddr = head_r[AW-1:0];
    adv = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (start) begin
          addr_nxt = '0;
          st_nxt = S_CLR;
        end
      end
      S_CLR: begin
        rch_we = 1'b1;
        addr_nxt = addr_r + AW'(1);
        if (addr_r == AW'(DEPTH - 1)) begin
          st_nxt = S_SEED;
        end
      end
      S_SEED: begin
        rch_we = 1'b1;
        rch_waddr = src;
        rch_wdata = 1'b1;
        q_we = 1'b1;
        q_waddr = '0;
        q_wdata = src;
        head_nxt = '0;
        tail_nxt = (AW+1)'(1);
        st_nxt = S_POP;
      end
      S_POP: begin
        if (head_r == tail_r) begin
          stat_nxt.done = 1'b1;
          stat_nxt.found = 1'b0;
          st_nxt = S_IDLE;
        end else begin
          st_nxt = S_CUR;
        end
      end
      S_CUR: begin
        cur_nxt = queue_q;
        dir_nxt = DIR_UP;
        st_nxt = S_NB;
      end
      S_NB: begin
        if (nb_ok) begin
          nb_nxt = nb_c;
          st_nxt = S_CHK;
        end else begin
          adv = 1'b1;
        end
      end
      S_CHK: begin
        adv = 1'b1;
        if (!reached_q && grid_rdata == '0) begin
          if (nb_r == tgt) begin
            adv = 1'b0;
            stat_nxt.done = 1'b1;
            stat_nxt.found = 1'b1;
            st_nxt = S_IDLE;
          end else begin
            rch_we = 1'b1;
            rch_waddr = nb_r;
            rch_wdata = 1'b1;
            q_we = 1'b1;
            tail_nxt = tail_r + (AW+1)'(1);
          end
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
    // step to the next direction, or drop the current cell after the last one
    if (adv) begin
      if (dir_r == DIR_RIGHT) begin
        head_nxt = head_r + (AW+1)'(1);
        st_nxt = S_POP;
      end else begin
        dir_nxt = dir_r + 2'd1;
        st_nxt = S_NB;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rch_we) begin
      reached_mem[rch_waddr] <= rch_wdata;
    end
    reached_q <= reached_mem[rch_raddr];
    if (q_we) begin
      queue_mem[q_waddr] <= q_wdata;
    end
    queue_q <= queue_mem[q_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      stat_r <= '0;
      head_r <= '0;
      tail_r <= '0;
    end else begin
      st_r <= st_nxt;
      stat_r <= stat_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    cur_r <= cur_nxt;
    nb_r <= nb_nxt;
    dir_r <= dir_nxt;
  end

  assign stat = stat_r;

  `GPME_ASSERT(a_head_le_tail, head_r <= tail_r, "search queue head passed tail")
  `GPME_ASSERT(a_tail_bound, tail_r <= (AW+1)'(DEPTH), "search queue overflow")
  `GPME_ASSERT_NEXT(a_done_idle, stat_nxt.done, st_r == S_IDLE, "search done outside idle")

endmodule

// ===== tb/grid_path_move_engine_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the grid path move engine: directed table, then random requests.
// Depends on gpme_pkg and grid_path_move_engine; holds its own grid model for prediction.
module grid_path_move_engine_test;
  import gpme_pkg::*;

  localparam int GRID_DIM = 16;
  localparam int CELLS = GRID_DIM * GRID_DIM;
  localparam int DRAIN_CYCLES = 3000;
  localparam longint CYCLE_LIMIT = 64'd20000000;
  localparam logic [1:0] CMD_IGNORED = 2'd3;
  localparam logic [3:0] ANY = 4'hF;

  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] fr;
    logic [3:0] fc;
    logic [3:0] tr;
    logic [3:0] tc;
    logic [3:0] color;
  } request_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] cell_color;
  } outcome_t;

  // One directed row: the request, whether the outcome is typed in, and that outcome.
  typedef struct packed {
    request_t req;
    logic fixed;
    outcome_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_ROW_COUNT;
  logic [CFG_W-1:0] cfg_data = '0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_cmd = CMD_WRITE;
  logic [3:0] in_from_row = '0, in_from_col = '0, in_to_row = '0, in_to_col = '0;
  logic [3:0] in_color = '0;
  logic out_valid;
  logic [1:0] out_status;
  logic [3:0] out_cell_color;

  // Grid model and size registers as the block should hold them.
  logic [3:0] grid_model [CELLS];
  logic [4:0] rows_cfg, cols_cfg;
  outcome_t pending_outcomes [$];
  int fail_count = 0;
  longint cycle_count = 0;
  int send_idle_pct = 0;

  grid_path_move_engine DUT (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .start, .busy,
    .in_cmd, .in_from_row, .in_from_col, .in_to_row, .in_to_col, .in_color,
    .out_valid, .out_status, .out_cell_color
  );

  always #4 clk = ~clk;

  // Abandon the run if the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int used_rows();
    return rows_cfg > GRID_DIM ? GRID_DIM : int'(rows_cfg);
  endfunction

  function automatic int used_cols();
    return cols_cfg > GRID_DIM ? GRID_DIM : int'(cols_cfg);
  endfunction

  function automatic bit in_area(logic [3:0] r, logic [3:0] c);
    return int'(r) < used_rows() && int'(c) < used_cols();
  endfunction

  // Flood through empty cells from the source; report whether the target is reached.
  function automatic bit reachable(int sr, int sc, int tr, int tc);
    bit seen [CELLS];
    int frontier [$];
    int cur, nr, nc, d;
    int dr [4] = '{-1, 1, 0, 0};
    int dc [4] = '{0, 0, -1, 1};
    foreach (seen[i]) seen[i] = 1'b0;
    seen[sr * GRID_DIM + sc] = 1'b1;
    frontier.push_back(sr * GRID_DIM + sc);
    while (frontier.size() > 0) begin
      cur = frontier.pop_front();
      if (cur == tr * GRID_DIM + tc) return 1'b1;
      for (d = 0; d < 4; d++) begin
        nr = cur / GRID_DIM + dr[d];
        nc = cur % GRID_DIM + dc[d];
        if (nr < 0 || nr >= used_rows() || nc < 0 || nc >= used_cols()) continue;
        if (seen[nr * GRID_DIM + nc] || grid_model[nr * GRID_DIM + nc] != 0) continue;
        seen[nr * GRID_DIM + nc] = 1'b1;
        frontier.push_back(nr * GRID_DIM + nc);
      end
    end
    return 1'b0;
  endfunction

  // Apply one request to the grid model and return the outcome it must give.
  function automatic outcome_t apply_request(request_t rq);
    outcome_t o;
    int src, dst;
    o = '0;
    src = int'(rq.fr) * GRID_DIM + int'(rq.fc);
    dst = int'(rq.tr) * GRID_DIM + int'(rq.tc);
    case (rq.cmd)
      CMD_WRITE: begin
        if (!in_area(rq.fr, rq.fc)) o.status = STS_OUT_OF_RANGE;
        else grid_model[src] = rq.color;
      end
      CMD_READ: begin
        if (!in_area(rq.fr, rq.fc)) o.status = STS_OUT_OF_RANGE;
        else o.cell_color = grid_model[src];
      end
      CMD_MOVE: begin
        if (!in_area(rq.fr, rq.fc) || !in_area(rq.tr, rq.tc)) o.status = STS_OUT_OF_RANGE;
        else if (grid_model[dst] != 0) o.status = STS_OCCUPIED;
        else if (!reachable(rq.fr, rq.fc, rq.tr, rq.tc)) o.status = STS_NO_PATH;
        else begin
          grid_model[dst] = grid_model[src];
          grid_model[src] = 4'd0;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // Check each strobed result against the oldest outcome held.
  always @(posedge clk) begin
    outcome_t w;
    if (rst_n && out_valid) begin
      if (pending_outcomes.size() == 0) begin
        $error("unexpected result: status %0d cell_color %0d", out_status, out_cell_color);
        fail_count++;
      end else begin
        w = pending_outcomes.pop_front();
        if (out_status !== w.status) begin
          $error("status: expected %0d, got %0d", w.status, out_status);
          fail_count++;
        end
        if (out_cell_color !== w.cell_color) begin
          $error("cell_color: expected %0d, got %0d", w.cell_color, out_cell_color);
          fail_count++;
        end
      end
    end
  end

  // Present one request and hold it until taken; start drops only when the sender idles.
  task automatic issue(request_t rq, bit fixed = 1'b0, outcome_t want = '0);
    outcome_t pred;
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    {in_cmd, in_from_row, in_from_col, in_to_row, in_to_col, in_color} <= rq;
    do @(posedge clk); while (busy);
    pred = apply_request(rq);
    if (fixed && pred != want) begin
      $error("table row disagrees with prediction: expected %0h, predicted %0h", want, pred);
      fail_count++;
    end
    pending_outcomes.push_back(pred);
  endtask

  // Wait for every outstanding result, then let the search finish before touching registers.
  task automatic drain();
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write enable is left high; the caller drops it after the last write.
  task automatic write_size(logic idx, logic [4:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == CFG_ROW_COUNT) rows_cfg = val;
    else cols_cfg = val;
  endtask

  function automatic request_t rand_request(bit in_range_bias);
    request_t rq;
    logic [31:0] raw;
    int r;
    raw = $urandom();
    rq = raw[$bits(request_t)-1:0];
    r = $urandom_range(99, 0);
    rq.cmd = r < 45 ? CMD_MOVE : r < 75 ? CMD_WRITE : r < 97 ? CMD_READ : CMD_IGNORED;
    if (in_range_bias && $urandom_range(9, 0) != 0) begin
      rq.fr = 4'($urandom_range(used_rows() - 1, 0));
      rq.fc = 4'($urandom_range(used_cols() - 1, 0));
      rq.tr = 4'($urandom_range(used_rows() - 1, 0));
      rq.tc = 4'($urandom_range(used_cols() - 1, 0));
    end
    // Keep the grid sparse enough that paths exist often.
    if (rq.cmd == CMD_WRITE && $urandom_range(2, 0) == 0) rq.color = 4'd0;
    return rq;
  endfunction

  // Directed rows at the reset size of nine by nine.
  row_t directed [] = '{
    '{'{CMD_READ,  4'd0, 4'd0, 4'd0, 4'd0, 4'd0}, 1'b1, '{STS_DONE, 4'd0}},
    '{'{CMD_WRITE, 4'd8, 4'd8, 4'd0, 4'd0, ANY},  1'b1, '{STS_DONE, 4'd0}},
    '{'{CMD_READ,  4'd8, 4'd8, 4'd0, 4'd0, 4'd0}, 1'b1, '{STS_DONE, ANY}},
    '{'{CMD_WRITE, 4'd9, 4'd0, 4'd0, 4'd0, 4'd5}, 1'b1, '{STS_OUT_OF_RANGE, 4'd0}},
    '{'{CMD_READ,  4'd0, 4'd9, 4'd0, 4'd0, 4'd0}, 1'b1, '{STS_OUT_OF_RANGE, 4'd0}},
    '{'{CMD_READ,  ANY,  ANY,  4'd0, 4'd0, 4'd0}, 1'b1, '{STS_OUT_OF_RANGE, 4'd0}},
    '{'{CMD_MOVE,  4'd0, 4'd0, 4'd9, 4'd9, 4'd0}, 1'b1, '{STS_OUT_OF_RANGE, 4'd0}},
    '{'{CMD_MOVE,  ANY,  4'd0, 4'd0, 4'd0, 4'd0}, 1'b1, '{STS_OUT_OF_RANGE, 4'd0}},
    '{'{CMD_MOVE,  4'd0, 4'd0, 4'd8, 4'd8, 4'd0}, 1'b1, '{STS_OCCUPIED, 4'd0}},
    '{'{CMD_WRITE, 4'd0, 4'd0, 4'd0, 4'd0, 4'd3}, 1'b0, '0},
    '{'{CMD_MOVE,  4'd0, 4'd0, 4'd4, 4'd4, 4'd0}, 1'b0, '0},
    '{'{CMD_READ,  4'd4, 4'd4, 4'd0, 4'd0, 4'd0}, 1'b0, '0},
    '{'{CMD_MOVE,  4'd2, 4'd2, 4'd2, 4'd2, 4'd0}, 1'b0, '0},
    '{'{CMD_MOVE,  4'd1, 4'd1, 4'd7, 4'd0, 4'd0}, 1'b0, '0},
    '{'{CMD_WRITE, 4'd7, 4'd8, 4'd0, 4'd0, 4'd6}, 1'b0, '0},
    '{'{CMD_WRITE, 4'd8, 4'd7, 4'd0, 4'd0, 4'd6}, 1'b0, '0},
    '{'{CMD_WRITE, 4'd8, 4'd8, 4'd0, 4'd0, 4'd0}, 1'b0, '0},
    '{'{CMD_MOVE,  4'd4, 4'd4, 4'd8, 4'd8, 4'd0}, 1'b0, '0},
    '{'{CMD_IGNORED, ANY, ANY, ANY, ANY, ANY},    1'b1, '{STS_DONE, 4'd0}},
    '{'{CMD_READ,  4'd4, 4'd4, 4'd0, 4'd0, 4'd0}, 1'b0, '0}
  };

  // Size settings per phase, extremes included; a count above sixteen saturates.
  logic [4:0] phase_rows [] = '{5'd16, 5'd1, 5'd31, 5'd4, 5'd0, 5'd16, 5'd7};
  logic [4:0] phase_cols [] = '{5'd16, 5'd16, 5'd1, 5'd31, 5'd5, 5'd0, 5'd3};
  int phase_idle [] = '{0, 50, 0, 28, 50, 0, 28};

  initial begin
    request_t rq;
    foreach (grid_model[i]) grid_model[i] = 4'd0;
    rows_cfg = COUNT_RESET;
    cols_cfg = COUNT_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) issue(directed[i].req, directed[i].fixed, directed[i].want);
    // Hold off until the block has answered everything.
    drain();

    foreach (phase_rows[p]) begin
      write_size(CFG_ROW_COUNT, phase_rows[p]);
      write_size(CFG_COL_COUNT, phase_cols[p]);
      cfg_we <= 1'b0;
      send_idle_pct = phase_idle[p];
      // Zero sizes leave no cell in range: keep that phase short.
      for (int n = 0; n < (phase_rows[p] == 0 || phase_cols[p] == 0 ? 40 : 230); n++) begin
        rq = rand_request(used_rows() > 0 && used_cols() > 0);
        issue(rq);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
